>>> src/hcs_pkg.sv
// Shared types, constants and rotate helpers for the Hilbert curve successor.
package hcs_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int COORD_BITS = 16;
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int CNT_W      = $clog2(MAX_DIMS + 1);
    localparam int LVL_W      = $clog2(COORD_BITS);
    localparam int NB_W       = $clog2(COORD_BITS + 1);
    localparam int DC_W       = 4;
    localparam int BPC_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int ROT_W2     = 2 * MAX_DIMS;

    typedef enum logic {
        CFG_DIM_COUNT      = 1'b0,
        CFG_BITS_PER_COORD = 1'b1
    } cfg_idx_t;

    typedef logic [MAX_DIMS-1:0]   dmask_t;
    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [NB_W-1:0]  nb;
        dmask_t           nd_ones;
    } cfg_t;

    typedef struct packed {
        coord_t [MAX_DIMS-1:0] coord;
        dmask_t                refl;
        logic [DIM_W-1:0]      rot;
        dmask_t                index;
        logic [LVL_W-1:0]      rb;
        dmask_t                rd;
    } walk_t;

    function automatic dmask_t rotr(dmask_t x, logic [DIM_W-1:0] r,
                                    logic [CNT_W-1:0] n, dmask_t mask);
        logic [ROT_W2-1:0] w;
        logic [CNT_W-1:0]  s;
        s = n - CNT_W'(r);
        w = (ROT_W2'(x) >> r) | (ROT_W2'(x) << s);
        return w[MAX_DIMS-1:0] & mask;
    endfunction

    function automatic dmask_t rotl(dmask_t x, logic [DIM_W-1:0] r,
                                    logic [CNT_W-1:0] n, dmask_t mask);
        logic [ROT_W2-1:0] w;
        logic [CNT_W-1:0]  s;
        s = n - CNT_W'(r);
        w = (ROT_W2'(x) << r) | (ROT_W2'(x) >> s);
        return w[MAX_DIMS-1:0] & mask;
    endfunction

endpackage

>>> src/hcs_level.sv
// One bit level of the Hilbert walk with its pipeline register.
module hcs_level (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hcs_pkg::LVL_W-1:0]     lvl,
    input  hcs_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hcs_pkg::walk_t                in_state,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hcs_pkg::walk_t                out_state
);

    logic                          valid_reg;
    hcs_pkg::walk_t                state_reg;
    hcs_pkg::walk_t                state_next;
    hcs_pkg::dmask_t               refl_new;
    hcs_pkg::dmask_t               bits;
    hcs_pkg::dmask_t               idx;
    hcs_pkg::dmask_t               inc;
    hcs_pkg::dmask_t               low_inc;
    hcs_pkg::dmask_t               low;
    logic                          full;
    logic [hcs_pkg::DIM_W:0]       step;
    logic [hcs_pkg::DIM_W:0]       rsum;

    always_comb
    begin
        state_next = in_state;
        for (int d = 0; d < hcs_pkg::MAX_DIMS; d++)
        begin
            refl_new[d] = (hcs_pkg::CNT_W'(d) < cfg.n) & in_state.coord[d][lvl];
        end
        bits = hcs_pkg::rotr(in_state.refl ^ refl_new, in_state.rot, cfg.n, cfg.nd_ones);
        idx = in_state.index ^ bits;
        for (int k = 1; k < hcs_pkg::MAX_DIMS; k = k * 2)
        begin
            idx = idx ^ (idx >> k);
        end
        full    = (idx == cfg.nd_ones);
        inc     = idx + hcs_pkg::dmask_t'(1);
        low_inc = inc & (~inc + hcs_pkg::dmask_t'(1));
        low     = bits & (~bits + hcs_pkg::dmask_t'(1)) & (cfg.nd_ones >> 1);
        step    = (hcs_pkg::DIM_W + 1)'(1);
        for (int j = 0; j < hcs_pkg::MAX_DIMS; j++)
        begin
            if (low[j])
            begin
                step = (hcs_pkg::DIM_W + 1)'(j + 2);
            end
        end
        rsum = {1'b0, in_state.rot} + step;
        if (rsum >= (hcs_pkg::DIM_W + 1)'(cfg.n))
        begin
            rsum = rsum - (hcs_pkg::DIM_W + 1)'(cfg.n);
        end
        if (hcs_pkg::NB_W'(lvl) < cfg.nb)
        begin
            if (!full)
            begin
                state_next.rb = lvl;
                state_next.rd = hcs_pkg::rotl(low_inc, in_state.rot, cfg.n, cfg.nd_ones);
            end
            state_next.index = idx[0] ? '0
                             : (hcs_pkg::dmask_t'(1) << (cfg.n - hcs_pkg::CNT_W'(1)));
            state_next.refl  = refl_new ^ (hcs_pkg::dmask_t'(1) << in_state.rot);
            state_next.rot   = rsum[hcs_pkg::DIM_W-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/hcs_out.sv
// Final stage: pick the changed dimension, flip its low bits, hold the result.
module hcs_out (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  hcs_pkg::cfg_t                                 cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  hcs_pkg::walk_t                                in_state,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output hcs_pkg::coord_t [hcs_pkg::MAX_DIMS-1:0]       out_coord,
    output logic [hcs_pkg::DIM_W-1:0]                     out_dim
);

    logic                                       valid_reg;
    hcs_pkg::coord_t [hcs_pkg::MAX_DIMS-1:0]    coord_reg;
    hcs_pkg::coord_t [hcs_pkg::MAX_DIMS-1:0]    coord_next;
    logic [hcs_pkg::DIM_W-1:0]                  dim_reg;
    logic [hcs_pkg::DIM_W-1:0]                  dim_next;
    hcs_pkg::coord_t                            flip;

    always_comb
    begin
        dim_next = hcs_pkg::DIM_W'(cfg.n - hcs_pkg::CNT_W'(1));
        for (int i = hcs_pkg::MAX_DIMS - 1; i >= 0; i--)
        begin
            if ((hcs_pkg::CNT_W'(i) < cfg.n - hcs_pkg::CNT_W'(1)) && in_state.rd[i])
            begin
                dim_next = hcs_pkg::DIM_W'(i);
            end
        end
        flip = {hcs_pkg::COORD_BITS{1'b1}}
             >> (hcs_pkg::LVL_W'(hcs_pkg::COORD_BITS - 1) - in_state.rb);
        coord_next = in_state.coord;
        coord_next[dim_next] = in_state.coord[dim_next] ^ flip;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_coord = coord_reg;
    assign out_dim   = dim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            coord_reg <= coord_next;
            dim_reg   <= dim_next;
        end
    end

endmodule

>>> src/hilbert_curve_successor_top.sv
// Top level of the Hilbert curve successor: config registers and the level pipeline.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_coord_0 .. in_coord_7
//   out      output     out_valid / out_ready  out_coord_0 .. out_coord_7, changed_dim
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle is accepted while not stalled; there is one register
// stage per coordinate bit level plus the flip stage. Levels above bits_per_coord pass
// the walk state through. Each stage holds its own valid bit, so bubbles close up under
// a stall and nothing is lost or repeated. Reset clears valid bits and restores
// dim_count = 2, bits_per_coord = 16. cfg_ready is always high.
module hilbert_curve_successor_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       in_coord_0,
    input  logic [15:0]                       in_coord_1,
    input  logic [15:0]                       in_coord_2,
    input  logic [15:0]                       in_coord_3,
    input  logic [15:0]                       in_coord_4,
    input  logic [15:0]                       in_coord_5,
    input  logic [15:0]                       in_coord_6,
    input  logic [15:0]                       in_coord_7,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       out_coord_0,
    output logic [15:0]                       out_coord_1,
    output logic [15:0]                       out_coord_2,
    output logic [15:0]                       out_coord_3,
    output logic [15:0]                       out_coord_4,
    output logic [15:0]                       out_coord_5,
    output logic [15:0]                       out_coord_6,
    output logic [15:0]                       out_coord_7,
    output logic [2:0]                        changed_dim,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  hcs_pkg::cfg_idx_t                 cfg_index,
    input  logic [hcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [hcs_pkg::DC_W-1:0]                   dim_count_reg;
    logic [hcs_pkg::BPC_W-1:0]                  bpc_reg;
    hcs_pkg::cfg_t                              cfg;
    logic [hcs_pkg::MAX_DIMS:0]                 one_sh;
    hcs_pkg::walk_t                             st    [0:hcs_pkg::COORD_BITS];
    logic [hcs_pkg::COORD_BITS:0]               vld;
    logic [hcs_pkg::COORD_BITS:0]               rdy;
    hcs_pkg::coord_t [hcs_pkg::MAX_DIMS-1:0]    res_coord;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= hcs_pkg::DC_W'(2);
            bpc_reg       <= hcs_pkg::BPC_W'(hcs_pkg::COORD_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hcs_pkg::CFG_DIM_COUNT:      dim_count_reg <= cfg_data[hcs_pkg::DC_W-1:0];
                hcs_pkg::CFG_BITS_PER_COORD: bpc_reg <= cfg_data[hcs_pkg::BPC_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        if (dim_count_reg < hcs_pkg::DC_W'(2))
            cfg.n = hcs_pkg::CNT_W'(2);
        else if (dim_count_reg > hcs_pkg::DC_W'(hcs_pkg::MAX_DIMS))
            cfg.n = hcs_pkg::CNT_W'(hcs_pkg::MAX_DIMS);
        else
            cfg.n = hcs_pkg::CNT_W'(dim_count_reg);
        if (bpc_reg < hcs_pkg::BPC_W'(1))
            cfg.nb = hcs_pkg::NB_W'(1);
        else if (bpc_reg > hcs_pkg::BPC_W'(hcs_pkg::COORD_BITS))
            cfg.nb = hcs_pkg::NB_W'(hcs_pkg::COORD_BITS);
        else
            cfg.nb = hcs_pkg::NB_W'(bpc_reg);
        one_sh      = (hcs_pkg::MAX_DIMS + 1)'(1) << cfg.n;
        cfg.nd_ones = one_sh[hcs_pkg::MAX_DIMS-1:0] - hcs_pkg::dmask_t'(1);
    end

    always_comb
    begin
        st[0].coord[0] = in_coord_0;
        st[0].coord[1] = in_coord_1;
        st[0].coord[2] = in_coord_2;
        st[0].coord[3] = in_coord_3;
        st[0].coord[4] = in_coord_4;
        st[0].coord[5] = in_coord_5;
        st[0].coord[6] = in_coord_6;
        st[0].coord[7] = in_coord_7;
        st[0].refl     = '0;
        st[0].rot      = '0;
        st[0].index    = '0;
        st[0].rb       = hcs_pkg::LVL_W'(cfg.nb - hcs_pkg::NB_W'(1));
        st[0].rd       = cfg.nd_ones;
    end

    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < hcs_pkg::COORD_BITS; k++)
    begin : g_level
        hcs_level u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .lvl       (hcs_pkg::LVL_W'(hcs_pkg::COORD_BITS - 1 - k)),
            .cfg       (cfg),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_state  (st[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_state (st[k+1])
        );
    end

    hcs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (vld[hcs_pkg::COORD_BITS]),
        .in_ready  (rdy[hcs_pkg::COORD_BITS]),
        .in_state  (st[hcs_pkg::COORD_BITS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_coord (res_coord),
        .out_dim   (changed_dim)
    );

    assign out_coord_0 = res_coord[0];
    assign out_coord_1 = res_coord[1];
    assign out_coord_2 = res_coord[2];
    assign out_coord_3 = res_coord[3];
    assign out_coord_4 = res_coord[4];
    assign out_coord_5 = res_coord[5];
    assign out_coord_6 = res_coord[6];
    assign out_coord_7 = res_coord[7];

endmodule

>>> src/hcs_checker.sv
// Port-level checks for the Hilbert curve successor, bound to the top level.
module hcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [15:0]                       out_coord_0,
    input  logic [15:0]                       out_coord_1,
    input  logic [15:0]                       out_coord_2,
    input  logic [15:0]                       out_coord_3,
    input  logic [15:0]                       out_coord_4,
    input  logic [15:0]                       out_coord_5,
    input  logic [15:0]                       out_coord_6,
    input  logic [15:0]                       out_coord_7,
    input  logic [2:0]                        changed_dim,
    input  logic                              cfg_ready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(changed_dim)
            && $stable(out_coord_0) && $stable(out_coord_1) && $stable(out_coord_2)
            && $stable(out_coord_3) && $stable(out_coord_4) && $stable(out_coord_5)
            && $stable(out_coord_6) && $stable(out_coord_7))
        else $error("result changed while stalled");

    // drop a result only after its transaction
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without a transaction");

    // an empty output stage lets the whole pipeline advance
    a_in_open: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage empty");

    a_cfg_open: assert property (@(posedge clk)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind hilbert_curve_successor_top hcs_checker u_hcs_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the Hilbert curve successor: random stall driver, monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = hcs_pkg::COORD_BITS + 1;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_PHASE = 12;
    localparam int PHASE_ITEMS = 52;

    typedef hcs_pkg::coord_t [hcs_pkg::MAX_DIMS-1:0] point_t;

    typedef struct packed {
        point_t     coord;
        logic [2:0] dim;
    } successor_t;

    typedef struct packed {
        hcs_pkg::cfg_idx_t idx;
        logic [4:0]        data;
    } reg_write_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    point_t            in_pt = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    wire point_t       out_pt;
    logic [2:0]        changed_dim;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    hcs_pkg::cfg_idx_t cfg_index = hcs_pkg::CFG_DIM_COUNT;
    logic [4:0]        cfg_data = '0;

    point_t     point_q[$];
    reg_write_t reg_write_q[$];
    successor_t expected_successors[$];

    logic [3:0] model_dc = 4'd2;
    logic [4:0] model_bpc = 5'd16;
    logic [3:0] grid_dc = 4'd2;
    logic [4:0] grid_bpc = 5'd16;
    logic       calm = 1'b0;
    int         mismatch_count = 0;
    int         stall_cycles = 0;

    hilbert_curve_successor_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_coord_0  (in_pt[0]),
        .in_coord_1  (in_pt[1]),
        .in_coord_2  (in_pt[2]),
        .in_coord_3  (in_pt[3]),
        .in_coord_4  (in_pt[4]),
        .in_coord_5  (in_pt[5]),
        .in_coord_6  (in_pt[6]),
        .in_coord_7  (in_pt[7]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_coord_0 (out_pt[0]),
        .out_coord_1 (out_pt[1]),
        .out_coord_2 (out_pt[2]),
        .out_coord_3 (out_pt[3]),
        .out_coord_4 (out_pt[4]),
        .out_coord_5 (out_pt[5]),
        .out_coord_6 (out_pt[6]),
        .out_coord_7 (out_pt[7]),
        .changed_dim (changed_dim),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic successor_t hilbert_next(logic [3:0] dc, logic [4:0] bpc, point_t pt);
        logic [31:0] n, nb, full, half, rot, refl, idx, rb, rd, bits, low, d, k;
        int          lvl;
        successor_t  res;
        n = 32'(dc);
        if (n < 2) n = 2;
        if (n > hcs_pkg::MAX_DIMS) n = hcs_pkg::MAX_DIMS;
        nb = 32'(bpc);
        if (nb < 1) nb = 1;
        if (nb > hcs_pkg::COORD_BITS) nb = hcs_pkg::COORD_BITS;
        full = (32'd1 << n) - 32'd1;
        half = full >> 1;
        rb = nb - 32'd1;
        rd = full;
        rot = '0;
        refl = '0;
        idx = '0;
        for (lvl = int'(nb) - 1; lvl >= 0; lvl--)
        begin
            bits = refl;
            refl = '0;
            for (d = 0; d < n; d++)
                refl[d] = pt[d][lvl];
            bits ^= refl;
            if (rot != 0)
                bits = ((bits >> rot) | (bits << (n - rot))) & full;
            else
                bits &= full;
            idx ^= bits;
            for (k = 1; k < n; k = k * 2)
                idx ^= idx >> k;
            if (idx != full)
            begin
                idx += 32'd1;
                rb = 32'(lvl);
                rd = idx & (~idx + 32'd1);
                if (rot != 0)
                    rd = ((rd << rot) | (rd >> (n - rot))) & full;
                else
                    rd &= full;
            end
            else
                idx += 32'd1;
            idx &= 32'd1;
            idx <<= (n - 32'd1);
            refl ^= 32'd1 << rot;
            low = bits & (~bits + 32'd1) & half;
            while (low != 0)
            begin
                low >>= 1;
                rot++;
            end
            rot++;
            if (rot >= n) rot -= n;
        end
        d = 0;
        while (d < n - 1 && rd[d] == 1'b0)
            d++;
        res.coord = pt;
        res.coord[d] = pt[d] ^ hcs_pkg::coord_t'((32'd2 << rb) - 32'd1);
        res.dim = d[2:0];
        return res;
    endfunction

    function automatic point_t rand_point();
        point_t pt;
        for (int i = 0; i < hcs_pkg::MAX_DIMS; i++)
            pt[i] = hcs_pkg::coord_t'($urandom_range(0, 65535));
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_pt <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (point_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                in_pt <= point_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk or negedge rst_n)
    begin : cfg_driver
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= hcs_pkg::CFG_DIM_COUNT;
            cfg_data <= '0;
        end
        else if (!cfg_valid || cfg_ready)
        begin
            if (reg_write_q.size() != 0)
            begin
                w = reg_write_q.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.idx;
                cfg_data <= w.data;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        successor_t exp_s;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hcs_pkg::CFG_DIM_COUNT:      model_dc = cfg_data[3:0];
                    hcs_pkg::CFG_BITS_PER_COORD: model_bpc = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_successors.push_back(hilbert_next(model_dc, model_bpc, in_pt));
            if (out_valid && out_ready)
            begin
                if (expected_successors.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected transaction on output", $realtime);
                end
                else
                begin
                    exp_s = expected_successors.pop_front();
                    for (int f = 0; f < hcs_pkg::MAX_DIMS; f++)
                    begin
                        if (out_pt[f] !== exp_s.coord[f])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("%0t: out_coord_%0d expected %h actual %h",
                                         $realtime, f, exp_s.coord[f], out_pt[f]);
                        end
                    end
                    if (changed_dim !== exp_s.dim)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: changed_dim expected %0d actual %0d",
                                     $realtime, exp_s.dim, changed_dim);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (point_q.size() != 0 || in_valid || expected_successors.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic set_grid(input logic [4:0] dc, input logic [4:0] bpc);
        wait_idle();
        reg_write_q.push_back('{idx: hcs_pkg::CFG_DIM_COUNT, data: dc});
        reg_write_q.push_back('{idx: hcs_pkg::CFG_BITS_PER_COORD, data: bpc});
        while (reg_write_q.size() != 0 || cfg_valid)
            @(posedge clk);
        grid_dc = dc[3:0];
        grid_bpc = bpc;
    endtask

    initial
    begin : stimulus
        point_t     pt;
        successor_t nxt;
        int         count;
        int         len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        point_q.push_back('0);
        point_q.push_back({hcs_pkg::MAX_DIMS{16'hFFFF}});
        point_q.push_back({hcs_pkg::MAX_DIMS{16'h8000}});
        point_q.push_back({4{16'hAAAA, 16'h5555}});
        point_q.push_back({hcs_pkg::MAX_DIMS{16'h0001}});

        set_grid(5'd2, 5'd1);
        for (int v = 0; v < 4; v++)
        begin
            pt = '0;
            pt[0] = hcs_pkg::coord_t'(v & 1);
            pt[1] = hcs_pkg::coord_t'(v >> 1);
            point_q.push_back(pt);
        end

        set_grid(5'd3, 5'd1);
        for (int v = 0; v < 8; v++)
        begin
            pt = rand_point();
            for (int i = 0; i < 3; i++)
                pt[i] = {pt[i][15:1], 1'(v >> i)};
            point_q.push_back(pt);
        end

        set_grid(5'd8, 5'd16);
        point_q.push_back('0);
        point_q.push_back({hcs_pkg::MAX_DIMS{16'hFFFF}});
        for (int i = 0; i < hcs_pkg::MAX_DIMS; i++)
            pt[i] = hcs_pkg::coord_t'(i * 16'h1111);
        point_q.push_back(pt);
        point_q.push_back(rand_point());

        set_grid(5'd0, 5'd0);
        point_q.push_back(rand_point());
        point_q.push_back(rand_point());

        set_grid(5'd31, 5'd31);
        point_q.push_back(rand_point());
        point_q.push_back(rand_point());

        for (int p = 0; p < RAND_PHASE; p++)
        begin
            if ($urandom_range(0, 9) < 7)
                set_grid(5'($urandom_range(2, 8)),
                         $urandom_range(0, 9) < 5 ? 5'($urandom_range(1, 4)) :
                         5'($urandom_range(1, 16)));
            else
                set_grid(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            calm = (p == 5);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                pt = rand_point();
                if ($urandom_range(0, 9) < 6)
                begin
                    len = $urandom_range(4, 16);
                    repeat (len)
                    begin
                        point_q.push_back(pt);
                        nxt = hilbert_next(grid_dc, grid_bpc, pt);
                        pt = nxt.coord;
                    end
                    count += len;
                end
                else
                begin
                    point_q.push_back(pt);
                    count++;
                end
            end
        end

        wait_idle();
        calm = 1'b0;
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_successors.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
